FILE: rtl/pfps_pkg.sv
package pfps_pkg;

  localparam int unsigned FlowsDefault = 1024;
  localparam int unsigned CfgIdxW      = 1;
  localparam logic [31:0] DropHorizonReset = 32'd2000000000;
  localparam logic [31:0] EcnHorizonReset  = 32'd500000000;
  localparam logic [29:0] NsPerSec = 30'd1000000000;
  localparam logic [19:0] NsPerMs  = 20'd1000000;
  localparam int unsigned QuotW = 46;
  localparam int unsigned DivCntW = 6;

  typedef enum logic [0:0] {
    CFG_DROP_HORIZON = 1'b0,
    CFG_ECN_HORIZON  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [9:0]  flow_slot;
    logic [15:0] packet_length;
    logic [63:0] packet_time;
    logic [63:0] now_time;
    logic [31:0] rate_bytes_per_sec;
    logic [15:0] extra_delay_ms;
  } in_item_t;

  typedef struct packed {
    logic        verdict;
    logic        ecn_mark;
    logic [63:0] departure_time;
  } out_item_t;

  // Prepared word handed from the front end to the back end.
  typedef struct packed {
    logic [9:0]  flow_slot;
    logic [63:0] packet_time;
    logic [63:0] now_time;
    logic [63:0] floor_time;
    logic [35:0] extra_ns;
    logic [QuotW-1:0] spacing;
  } work_t;

  typedef enum logic [1:0] {
    FE_IDLE = 2'd0,
    FE_MUL  = 2'd1,
    FE_DIV  = 2'd2,
    FE_PUSH = 2'd3
  } fe_state_e;

  typedef enum logic [2:0] {
    BE_IDLE  = 3'd0,
    BE_READ  = 3'd1,
    BE_PACE  = 3'd2,
    BE_DECIDE = 3'd3,
    BE_OUT   = 3'd4,
    BE_CLEAR = 3'd5
  } be_state_e;

endpackage

FILE: rtl/pfps_front.sv
module pfps_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid,
  output logic              in_ready,
  input  pfps_pkg::in_item_t in_data,
  output logic              wq_valid_o,
  input  logic              wq_ready_i,
  output pfps_pkg::work_t   wq_data_o
);
  import pfps_pkg::*;

  fe_state_e state_q, state_d;
  in_item_t  item_q;
  logic [45:0] num_q;
  logic [31:0] rate_q;
  logic [31:0] rem_q;
  logic [QuotW-1:0] quot_q;
  logic [DivCntW-1:0] cnt_q;
  logic [35:0] extra_q;
  logic [32:0] rem_sh;
  logic        sub_ok;

  // One quotient bit a cycle, restoring division.
  assign rem_sh = {rem_q, num_q[QuotW-1]};
  assign sub_ok = rem_sh >= {1'b0, rate_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FE_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == FE_MUL) cnt_q <= '0;
      else if (state_q == FE_DIV) cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      FE_IDLE: begin
        if (in_valid) item_q <= in_data;
      end
      FE_MUL: begin
        num_q   <= item_q.packet_length * NsPerSec;
        extra_q <= item_q.extra_delay_ms * NsPerMs;
        rate_q  <= item_q.rate_bytes_per_sec;
        rem_q   <= '0;
      end
      FE_DIV: begin
        num_q  <= {num_q[QuotW-2:0], 1'b0};
        rem_q  <= sub_ok ? 32'(rem_sh - {1'b0, rate_q}) : rem_sh[31:0];
        quot_q <= {quot_q[QuotW-2:0], sub_ok};
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    in_ready = 1'b0;
    unique case (state_q)
      FE_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_d = FE_MUL;
      end
      FE_MUL: state_d = FE_DIV;
      FE_DIV: if (cnt_q == DivCntW'(QuotW - 1)) state_d = FE_PUSH;
      FE_PUSH: if (wq_ready_i) state_d = FE_IDLE;
      default: state_d = FE_IDLE;
    endcase
  end

  assign wq_valid_o = state_q == FE_PUSH;
  always_comb begin
    wq_data_o.flow_slot   = item_q.flow_slot;
    wq_data_o.packet_time = item_q.packet_time;
    wq_data_o.now_time    = item_q.now_time;
    wq_data_o.floor_time  = (item_q.packet_time < item_q.now_time) ?
                            item_q.now_time : item_q.packet_time;
    wq_data_o.extra_ns    = extra_q;
    wq_data_o.spacing     = (rate_q == '0) ? '0 : quot_q;
  end

endmodule

FILE: rtl/pfps_queue.sv
module pfps_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  pfps_pkg::work_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output pfps_pkg::work_t pop_data_o
);
  import pfps_pkg::*;

  work_t mem_q [2];
  logic  wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign push_ready_o = cnt_q != 2'd2;
  assign pop_valid_o  = cnt_q != 2'd0;
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= push_data_i;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("queue count overflow");
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> cnt_q == $past(cnt_q) - 2'd1) else $error("pop count");
  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 2'd1) else $error("push count");
`endif

endmodule

FILE: rtl/pfps_back.sv
module pfps_back #(
  parameter int unsigned Flows = pfps_pkg::FlowsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wq_valid_i,
  output logic                wq_ready_o,
  input  pfps_pkg::work_t     wq_data_i,
  input  logic [31:0]         drop_horizon_i,
  input  logic [31:0]         ecn_horizon_i,
  output logic                out_valid,
  input  logic                out_ready,
  output pfps_pkg::out_item_t out_data
);
  import pfps_pkg::*;

  localparam int unsigned SlotW = (Flows > 1) ? $clog2(Flows) : 1;

  be_state_e state_q, state_d;
  work_t     w_q;
  logic [SlotW-1:0] slot;
  // Each entry holds its valid flag above the 64-bit departure time.
  logic [64:0] mem_q [Flows];
  logic [SlotW-1:0] clr_q;
  logic [63:0] rd_q;
  logic        rdv_q;
  logic [63:0] paced_q;
  logic [64:0] sum;
  logic [64:0] qdiff;
  logic [63:0] dep, base;
  logic [64:0] dsum;
  logic        pass, drop;
  out_item_t   res_q;
  logic        wr_en;
  logic [63:0] wr_data;

  always_comb begin
    if (Flows > 1) slot = SlotW'(32'(w_q.flow_slot) % Flows);
    else slot = '0;
  end

  assign sum   = {1'b0, rd_q} + 65'(w_q.spacing);
  assign pass  = paced_q <= w_q.floor_time;
  assign qdiff = {1'b0, paced_q} - {1'b0, w_q.now_time};
  assign drop  = !pass && (qdiff >= 65'(drop_horizon_i));
  assign base  = (w_q.packet_time == '0) ? w_q.now_time : w_q.packet_time;
  assign dep   = pass ? base : paced_q;
  assign dsum  = {1'b0, dep} + 65'(w_q.extra_ns);
  assign wr_en = state_q == BE_DECIDE && !drop;
  assign wr_data = pass ? w_q.floor_time : paced_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BE_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == BE_CLEAR) clr_q <= clr_q + 1'b1;
    end
  end

  // After reset every entry is cleared, one a cycle, before any word is taken.
  always_ff @(posedge clk_i) begin
    if (state_q == BE_CLEAR) mem_q[clr_q] <= '0;
    else if (wr_en) mem_q[slot] <= {1'b1, wr_data};
    if (state_q == BE_READ) begin
      {rdv_q, rd_q} <= mem_q[slot];
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BE_IDLE: if (wq_valid_i) w_q <= wq_data_i;
      BE_PACE: paced_q <= !rdv_q ? '0 : (sum[64] ? '1 : sum[63:0]);
      BE_DECIDE: begin
        res_q.verdict  <= drop;
        res_q.ecn_mark <= !pass && !drop && (qdiff >= 65'(ecn_horizon_i));
        res_q.departure_time <= drop ? '0 : (dsum[64] ? '1 : dsum[63:0]);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    wq_ready_o = 1'b0;
    unique case (state_q)
      BE_CLEAR:  if (clr_q == SlotW'(Flows - 1)) state_d = BE_IDLE;
      BE_IDLE: begin
        wq_ready_o = 1'b1;
        if (wq_valid_i) state_d = BE_READ;
      end
      BE_READ:   state_d = BE_PACE;
      BE_PACE:   state_d = BE_DECIDE;
      BE_DECIDE: state_d = BE_OUT;
      BE_OUT:    if (out_ready) state_d = BE_IDLE;
      default:   state_d = BE_IDLE;
    endcase
  end

  assign out_valid = state_q == BE_OUT;
  assign out_data  = res_q;

`ifndef SYNTHESIS
  a_drop_no_ecn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.verdict |-> !out_data.ecn_mark) else $error("drop with ecn");
  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.verdict |-> out_data.departure_time == '0)
    else $error("drop with time");
  a_write_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> state_q == BE_OUT) else $error("table write outside decide");
`endif

endmodule

FILE: rtl/per_flow_pacing_shaper_top.sv
// The front end multiplies, runs the bit-serial spacing divider and pushes each word into
// the queue; the back end reads the flow table, paces, decides and then offers the result.
// The front end takes a new word only after it has pushed its previous one into the queue.
// The back end overlaps the next word's division through a two-entry queue.
// Reset loads the horizon registers; the flow table (Flows entries, 1024 by default) is
// then cleared before the back end takes its first word.
module per_flow_pacing_shaper_top #(
  parameter int unsigned Flows = pfps_pkg::FlowsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid,
  output logic                in_ready,
  input  pfps_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pfps_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [pfps_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0]         cfg_data
);
  import pfps_pkg::*;

  logic [31:0] drop_q, ecn_q;
  logic  fq_valid, fq_ready, bq_valid, bq_ready;
  work_t fq_data, bq_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_q <= DropHorizonReset;
      ecn_q  <= EcnHorizonReset;
    end else if (cfg_valid) begin
      unique case (cfg_idx_e'(cfg_index))
        CFG_DROP_HORIZON: drop_q <= cfg_data;
        CFG_ECN_HORIZON:  ecn_q  <= cfg_data;
        default: ;
      endcase
    end
  end

  pfps_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_ready, .in_data,
    .wq_valid_o(fq_valid), .wq_ready_i(fq_ready), .wq_data_o(fq_data)
  );

  pfps_queue u_queue (
    .clk_i, .rst_ni,
    .push_valid_i(fq_valid), .push_ready_o(fq_ready), .push_data_i(fq_data),
    .pop_valid_o(bq_valid), .pop_ready_i(bq_ready), .pop_data_o(bq_data)
  );

  pfps_back #(.Flows(Flows)) u_back (
    .clk_i, .rst_ni,
    .wq_valid_i(bq_valid), .wq_ready_o(bq_ready), .wq_data_i(bq_data),
    .drop_horizon_i(drop_q), .ecn_horizon_i(ecn_q),
    .out_valid, .out_ready, .out_data
  );

endmodule

FILE: test/per_flow_pacing_shaper_top_test.sv
`timescale 1ns / 100ps

module per_flow_pacing_shaper_top_test;
  import pfps_pkg::*;

  localparam int unsigned Flows = 1024;
  localparam int unsigned IdleLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  per_flow_pacing_shaper_top #(.Flows(Flows)) u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the block's state.
  logic [63:0] shadow_depart [Flows];
  logic        shadow_valid [Flows];
  logic [31:0] drop_horizon;
  logic [31:0] ecn_horizon;

  in_item_t  pending_words[$];
  out_item_t expected_verdicts[$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  bit in_taken = 1'b0;

  function automatic logic [63:0] add_saturating(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
  endfunction

  function automatic out_item_t pace_packet(in_item_t w);
    out_item_t r;
    logic [9:0] slot;
    logic [63:0] spacing, paced, floor_t, extra, queued, base;
    slot = w.flow_slot % Flows;
    spacing = (w.rate_bytes_per_sec != 0) ?
              (64'(w.packet_length) * 64'd1000000000) / 64'(w.rate_bytes_per_sec) : 64'd0;
    extra = 64'(w.extra_delay_ms) * 64'd1000000;
    floor_t = (w.packet_time < w.now_time) ? w.now_time : w.packet_time;
    paced = shadow_valid[slot] ? add_saturating(shadow_depart[slot], spacing) : 64'd0;
    r = '0;
    if (paced <= floor_t) begin
      shadow_depart[slot] = floor_t;
      shadow_valid[slot] = 1'b1;
      base = (w.packet_time == 0) ? w.now_time : w.packet_time;
      r.departure_time = add_saturating(base, extra);
    end else begin
      queued = paced - w.now_time;
      if (queued >= 64'(drop_horizon)) begin
        r.verdict = 1'b1;
      end else begin
        r.ecn_mark = (queued >= 64'(ecn_horizon));
        shadow_depart[slot] = paced;
        shadow_valid[slot] = 1'b1;
        r.departure_time = add_saturating(paced, extra);
      end
    end
    return r;
  endfunction

  function automatic int unsigned random_gap();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  // Driver: one word in flight at a time from the pending queue.
  int unsigned send_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_taken) begin
        // hold the word
      end else begin
        in_taken = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= pending_words[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Sink: random back-pressure.
  int unsigned stall_left = 0;
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(7) == 0) stall_left = random_gap();
    end
  end

  // Monitor.
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
      if (in_valid && in_ready) begin
        expected_verdicts.push_back(pace_packet(in_data));
        void'(pending_words.pop_front());
        send_gap = random_gap();
        in_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          $error("result word with nothing expected");
          mismatch_count++;
        end else begin
          e = expected_verdicts.pop_front();
          if (out_data.verdict !== e.verdict) begin
            $error("verdict expected %0d actual %0d", e.verdict, out_data.verdict);
            mismatch_count++;
          end
          if (out_data.ecn_mark !== e.ecn_mark) begin
            $error("ecn_mark expected %0d actual %0d", e.ecn_mark, out_data.ecn_mark);
            mismatch_count++;
          end
          if (out_data.departure_time !== e.departure_time) begin
            $error("departure_time expected %0d actual %0d",
                   e.departure_time, out_data.departure_time);
            mismatch_count++;
          end
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid || expected_verdicts.size() > 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_horizon(cfg_idx_e idx, logic [31:0] value);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk_i); while (!cfg_ready);
    if (idx == CFG_DROP_HORIZON) drop_horizon = value;
    else ecn_horizon = value;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] random_wide();
    return {$urandom(), $urandom()};
  endfunction

  // Mostly well-paced traffic on a few busy flows, with some noise.
  task automatic queue_random_burst(int unsigned count, logic [63:0] start_ns);
    in_item_t w;
    logic [63:0] clock_ns;
    clock_ns = start_ns;
    repeat (count) begin
      w.flow_slot = ($urandom_range(3) != 0) ? 10'($urandom_range(7)) : 10'($urandom());
      w.packet_length = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(1500, 64));
      case ($urandom_range(5))
        0: w.rate_bytes_per_sec = 0;
        1: w.rate_bytes_per_sec = $urandom();
        2: w.rate_bytes_per_sec = $urandom_range(1000, 1);
        default: w.rate_bytes_per_sec = $urandom_range(200000000, 100000);
      endcase
      clock_ns = clock_ns + $urandom_range(20000);
      w.now_time = ($urandom_range(19) == 0) ? random_wide() : clock_ns;
      case ($urandom_range(3))
        0: w.packet_time = 0;
        1: w.packet_time = w.now_time + $urandom_range(100000);
        2: w.packet_time = random_wide();
        default: w.packet_time = w.now_time - $urandom_range(5000);
      endcase
      w.extra_delay_ms = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(3));
      pending_words.push_back(w);
    end
  endtask

  initial begin
    in_item_t w;
    for (int i = 0; i < Flows; i++) shadow_valid[i] = 1'b0;
    drop_horizon = DropHorizonReset;
    ecn_horizon = EcnHorizonReset;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: first use, extremes, zero rate, drop, marking, saturation.
    w = '0;
    pending_words.push_back(w);
    w.flow_slot = 10'h3FF; w.packet_length = 16'hFFFF; w.rate_bytes_per_sec = 1;
    w.now_time = 64'd1000; w.packet_time = 0; w.extra_delay_ms = 16'hFFFF;
    pending_words.push_back(w);
    pending_words.push_back(w);
    w.rate_bytes_per_sec = 32'hFFFF_FFFF;
    pending_words.push_back(w);
    w.flow_slot = 10'd5; w.packet_length = 16'd1000; w.rate_bytes_per_sec = 32'd1000;
    w.now_time = 64'd10; w.packet_time = 64'd20; w.extra_delay_ms = 0;
    pending_words.push_back(w);
    pending_words.push_back(w);
    w.rate_bytes_per_sec = 0;
    pending_words.push_back(w);
    w.flow_slot = 10'd6; w.packet_length = 16'd600; w.rate_bytes_per_sec = 32'd1000;
    w.now_time = 64'd100; w.packet_time = 0;
    pending_words.push_back(w);
    pending_words.push_back(w);
    pending_words.push_back(w);
    w.flow_slot = 10'd7; w.now_time = 64'hFFFF_FFFF_FFFF_FFF0;
    w.packet_time = 64'hFFFF_FFFF_FFFF_FFFF; w.extra_delay_ms = 16'd5;
    w.rate_bytes_per_sec = 32'd3;
    pending_words.push_back(w);
    pending_words.push_back(w);
    w.flow_slot = 10'd8; w.now_time = 64'd0; w.packet_time = 64'd0;
    pending_words.push_back(w);
    wait_drained();

    write_horizon(CFG_DROP_HORIZON, 32'hFFFF_FFFF);
    write_horizon(CFG_ECN_HORIZON, 32'd0);
    queue_random_burst(400, 64'd1_000_000);
    wait_drained();

    write_horizon(CFG_DROP_HORIZON, 32'd0);
    write_horizon(CFG_ECN_HORIZON, 32'hFFFF_FFFF);
    queue_random_burst(300, 64'd10_000_000_000);
    wait_drained();

    write_horizon(CFG_DROP_HORIZON, 32'd3_000_000);
    write_horizon(CFG_ECN_HORIZON, 32'd200_000);
    queue_random_burst(600, 64'd50_000_000_000);
    wait_drained();

    write_horizon(CFG_DROP_HORIZON, $urandom());
    write_horizon(CFG_ECN_HORIZON, $urandom_range(5_000_000));
    queue_random_burst(500, 64'd90_000_000_000);
    wait_drained();

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/pfps_pkg.sv
rtl/pfps_front.sv
rtl/pfps_queue.sv
rtl/pfps_back.sv
rtl/per_flow_pacing_shaper_top.sv
test/per_flow_pacing_shaper_top_test.sv
